FILE: design/bfv_pkg.sv
package bfv_pkg;

    localparam int MAX_CORNERS = 8;
    localparam int COORD_W     = 32;
    localparam int POINT_W     = 34;
    localparam int PROD_W      = 50;
    localparam int SUM_W       = 52;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_REGS    = 8;

    typedef logic signed [POINT_W-1:0] point_coord_t;
    typedef logic signed [SUM_W-1:0]   hsum_t;
    typedef logic [3:0][3:0][COORD_W-1:0] matrix_t;
    typedef logic [CFG_REGS-1:0][63:0] cfg_bank_t;

    localparam logic [63:0] CFG_RESET [CFG_REGS] = '{
        64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000, 64'h0,
        64'h0, 64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000
    };

endpackage

FILE: design/bfv_point_xform.sv
module bfv_point_xform
(
    input  logic                    clk,
    input  logic                    en,
    input  bfv_pkg::point_coord_t   px,
    input  bfv_pkg::point_coord_t   py,
    input  bfv_pkg::point_coord_t   pz,
    input  bfv_pkg::matrix_t        mat,
    output bfv_pkg::hsum_t          hx,
    output bfv_pkg::hsum_t          hy,
    output bfv_pkg::hsum_t          hz,
    output bfv_pkg::hsum_t          hw
);

    logic signed [bfv_pkg::PROD_W-1:0] prod_reg  [3][4];
    logic signed [bfv_pkg::PROD_W-1:0] prod_next [3][4];
    bfv_pkg::hsum_t sum_reg  [4];
    bfv_pkg::hsum_t sum_next [4];
    bfv_pkg::point_coord_t pt [3];
    logic signed [2*bfv_pkg::COORD_W+1:0] full [3][4];

    assign pt[0] = px;
    assign pt[1] = py;
    assign pt[2] = pz;

    // floor shift by 16 is just dropping the low bits
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                full[r][c]      = pt[r] * $signed(mat[r][c]);
                prod_next[r][c] = full[r][c][65:16];
            end
        end
    end

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            sum_next[c] = bfv_pkg::SUM_W'(prod_reg[0][c])
                        + bfv_pkg::SUM_W'(prod_reg[1][c])
                        + bfv_pkg::SUM_W'(prod_reg[2][c])
                        + bfv_pkg::SUM_W'($signed(mat[3][c]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            sum_reg  <= sum_next;
        end
    end

    assign hx = sum_reg[0];
    assign hy = sum_reg[1];
    assign hz = sum_reg[2];
    assign hw = sum_reg[3];

endmodule

FILE: design/bfv_bounds_check.sv
module bfv_bounds_check
(
    input  bfv_pkg::hsum_t hx,
    input  bfv_pkg::hsum_t hy,
    input  bfv_pkg::hsum_t hz,
    input  bfv_pkg::hsum_t hw,
    output logic           in_bounds
);

    localparam int CW = bfv_pkg::SUM_W + 3;

    logic signed [CW-1:0] w1, w3, nw1, nw3, nx, ny, nz;
    logic ok_x, ok_y, ok_z;

    always_comb
    begin
        w1  = CW'(hw);
        w3  = (w1 <<< 1) + w1;
        nw1 = -w1;
        nw3 = -w3;
        nx  = CW'(hx);
        ny  = CW'(hy);
        nz  = CW'(hz);
        // cross-multiplied ratio tests, bounds flip when w is negative
        if (!hw[bfv_pkg::SUM_W-1])
        begin
            ok_x = (nx > nw3) && (nx < w1);
            ok_y = (ny > nw1) && (ny < w3);
            ok_z = (nz > 0)   && (nz < w1);
        end
        else
        begin
            ok_x = (nx < nw3) && (nx > w1);
            ok_y = (ny < nw1) && (ny > w3);
            ok_z = (nz < 0)   && (nz > w1);
        end
        in_bounds = (hw != '0) && ok_x && ok_y && ok_z;
    end

endmodule

FILE: design/box_frustum_visibility_test_unit.sv
// Box visibility test against a 4x4 view-projection matrix.
// Input channel: in_valid / in_stall with box center, size and center_only.
// An item is taken at a clock edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall with inside_res, one per item.
// Config channel: cfg_valid / cfg_ready (always ready), cfg_index picks one
// of eight 64-bit matrix registers, two Q16.16 entries each; index beyond
// seven is dropped. Write configuration only while the pipeline is empty.
// Throughput: one item per cycle while no result is held with out_stall;
// four register stages (corners, products, row sums, bounds result) all
// advance together, every corner has its own twelve multipliers.
// Reset: valid bits clear, matrix returns to identity.
// Stall: while a result is held with out_stall high the whole pipeline
// freezes and in_stall goes high; nothing is lost or repeated.
module box_frustum_visibility_test_unit
#(
    parameter int CORNER_COUNT = 8
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [31:0]            center_x,
    input  logic signed [31:0]            center_y,
    input  logic signed [31:0]            center_z,
    input  logic signed [31:0]            size_x,
    input  logic signed [31:0]            size_y,
    input  logic signed [31:0]            size_z,
    input  logic                          center_only,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          inside_res,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bfv_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                   cfg_data
);

    bfv_pkg::cfg_bank_t cfg_reg;
    bfv_pkg::matrix_t   mat;
    logic en;
    logic v1_reg, v2_reg, v3_reg, out_valid_reg;
    logic [CORNER_COUNT-1:0] m1_reg, m2_reg, m3_reg, m1_next;
    logic [CORNER_COUNT-1:0] hit;
    logic res_reg;

    bfv_pkg::point_coord_t cxe, cye, cze, hxe, hye, hze;
    bfv_pkg::point_coord_t pxr [CORNER_COUNT];
    bfv_pkg::point_coord_t pyr [CORNER_COUNT];
    bfv_pkg::point_coord_t pzr [CORNER_COUNT];

    assign cfg_ready = 1'b1;

    // row r sits in registers 2r and 2r+1: even column low, odd column high
    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                mat[r][c] = (c % 2 == 1) ? cfg_reg[r*2 + c/2][63:32]
                                         : cfg_reg[r*2 + c/2][31:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < bfv_pkg::CFG_REGS; i++)
            begin
                cfg_reg[i] <= bfv_pkg::CFG_RESET[i];
            end
        end
        else if (cfg_valid && cfg_index < bfv_pkg::CFG_IDX_W'(bfv_pkg::CFG_REGS))
        begin
            cfg_reg[cfg_index[2:0]] <= cfg_data;
        end
    end

    // advance unless a finished item is held at the output
    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg        <= in_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            out_valid_reg <= v3_reg;
        end
    end

    // half size floors, corners are exact in 34 bits
    assign cxe = bfv_pkg::POINT_W'(center_x);
    assign cye = bfv_pkg::POINT_W'(center_y);
    assign cze = bfv_pkg::POINT_W'(center_z);
    assign hxe = bfv_pkg::POINT_W'(size_x >>> 1);
    assign hye = bfv_pkg::POINT_W'(size_y >>> 1);
    assign hze = bfv_pkg::POINT_W'(size_z >>> 1);

    always_comb
    begin
        for (int i = 0; i < CORNER_COUNT; i++)
        begin
            m1_next[i] = center_only ? (i == 0) : 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_reg <= m1_next;
            m2_reg <= m1_reg;
            m3_reg <= m2_reg;
            res_reg <= |(hit & m3_reg);
            for (int i = 0; i < CORNER_COUNT; i++)
            begin
                if (center_only)
                begin
                    pxr[i] <= cxe;
                    pyr[i] <= cye;
                    pzr[i] <= cze;
                end
                else
                begin
                    pxr[i] <= (i % 2 == 1)       ? cxe + hxe : cxe - hxe;
                    pyr[i] <= ((i / 2) % 2 == 1) ? cye + hye : cye - hye;
                    pzr[i] <= ((i / 4) % 2 == 1) ? cze + hze : cze - hze;
                end
            end
        end
    end

    for (genvar g = 0; g < CORNER_COUNT; g++)
    begin : g_corner
        bfv_pkg::hsum_t sx, sy, sz, sw;

        bfv_point_xform u_xform
        (
            .clk (clk),
            .en  (en),
            .px  (pxr[g]),
            .py  (pyr[g]),
            .pz  (pzr[g]),
            .mat (mat),
            .hx  (sx),
            .hy  (sy),
            .hz  (sz),
            .hw  (sw)
        );

        bfv_bounds_check u_check
        (
            .hx        (sx),
            .hy        (sy),
            .hz        (sz),
            .hw        (sw),
            .in_bounds (hit[g])
        );
    end

    assign out_valid  = out_valid_reg;
    assign inside_res = res_reg;

    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (en && v3_reg) |=> out_valid_reg)
        else $error("finished item did not reach output");

    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> ($stable(v1_reg) && $stable(v2_reg) && $stable(v3_reg)))
        else $error("pipeline moved while frozen");

    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(res_reg)))
        else $error("held result changed");

endmodule

FILE: dv/box_frustum_visibility_test_unit_test.sv
`timescale 1ns / 1ps

module box_frustum_visibility_test_unit_test;

    localparam int LATENCY   = 4;
    localparam int N_CORNERS = 8;

    // Register indexes of the matrix bank
    localparam logic [bfv_pkg::CFG_IDX_W-1:0] REG_R0_C01 = 0;
    localparam logic [bfv_pkg::CFG_IDX_W-1:0] REG_R0_C23 = 1;
    localparam logic [bfv_pkg::CFG_IDX_W-1:0] REG_R1_C01 = 2;
    localparam logic [bfv_pkg::CFG_IDX_W-1:0] REG_R1_C23 = 3;
    localparam logic [bfv_pkg::CFG_IDX_W-1:0] REG_R2_C01 = 4;
    localparam logic [bfv_pkg::CFG_IDX_W-1:0] REG_R2_C23 = 5;
    localparam logic [bfv_pkg::CFG_IDX_W-1:0] REG_R3_C01 = 6;
    localparam logic [bfv_pkg::CFG_IDX_W-1:0] REG_R3_C23 = 7;
    localparam logic [bfv_pkg::CFG_IDX_W-1:0] REG_OUT_OF_RANGE = 8;

    localparam logic [63:0] ONE_ENTRY = 64'h0000_0000_0001_0000;
    localparam logic [63:0] ONE_HIGH  = 64'h0001_0000_0000_0000;

    typedef struct packed {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [31:0] sz;
        logic               c_only;
    } box_t;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    logic signed [31:0]            center_x;
    logic signed [31:0]            center_y;
    logic signed [31:0]            center_z;
    logic signed [31:0]            size_x;
    logic signed [31:0]            size_y;
    logic signed [31:0]            size_z;
    logic                          center_only;
    logic                          out_valid;
    logic                          out_stall;
    logic                          inside_res;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [bfv_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [63:0]                   cfg_data;

    box_frustum_visibility_test_unit #(.CORNER_COUNT(N_CORNERS)) uut
    (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .center_x(center_x),
        .center_y(center_y),
        .center_z(center_z),
        .size_x(size_x),
        .size_y(size_y),
        .size_z(size_z),
        .center_only(center_only),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .inside_res(inside_res),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Testbench copy of the matrix bank
    logic [63:0] matrix_shadow [bfv_pkg::CFG_REGS];

    // Visibility bits still owed by the block, oldest first
    logic pending_visibility [$];

    int n_errors;
    int n_sent;
    int n_checked;
    int n_visible;
    int n_center_only;

    // Receiver hold-off request, served by the stall process
    int hold_cycles;
    bit random_stall_en;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Fetch matrix entry M[r][c] as a signed Q16.16 value
    function automatic longint mat_entry(int r, int c);
        logic [63:0] reg_word;
        reg_word = matrix_shadow[r * 2 + c / 2];
        return longint'($signed(c % 2 ? reg_word[63:32] : reg_word[31:0]));
    endfunction

    // Test strictly a < n/w < b without dividing
    function automatic bit ratio_in_range(longint n, longint w, longint a, longint b);
        if (w > 0)
            return (n > a * w) && (n < b * w);
        return (n < a * w) && (n > b * w);
    endfunction

    function automatic bit point_visible(longint x, longint y, longint z);
        longint o [4];
        for (int c = 0; c < 4; c++)
        begin
            // >>> on signed longint floors, matching the block's rounding
            o[c] = ((x * mat_entry(0, c)) >>> 16) + ((y * mat_entry(1, c)) >>> 16)
                 + ((z * mat_entry(2, c)) >>> 16) + mat_entry(3, c);
        end
        if (o[3] == 0)
            return 1'b0;
        return ratio_in_range(o[0], o[3], -3, 1) && ratio_in_range(o[1], o[3], -1, 3)
            && ratio_in_range(o[2], o[3], 0, 1);
    endfunction

    function automatic bit box_visible(box_t b);
        longint hx;
        longint hy;
        longint hz;
        longint px;
        longint py;
        longint pz;
        if (b.c_only)
            return point_visible(b.cx, b.cy, b.cz);
        hx = longint'(b.sx) >>> 1;
        hy = longint'(b.sy) >>> 1;
        hz = longint'(b.sz) >>> 1;
        for (int i = 0; i < N_CORNERS; i++)
        begin
            px = i[0] ? b.cx + hx : b.cx - hx;
            py = i[1] ? b.cy + hy : b.cy - hy;
            pz = i[2] ? b.cz + hz : b.cz - hz;
            if (point_visible(px, py, pz))
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Offer one item and hold it until taken; valid stays up for a following item
    task automatic send_box(box_t b);
        in_valid    <= 1'b1;
        center_x    <= b.cx;
        center_y    <= b.cy;
        center_z    <= b.cz;
        size_x      <= b.sx;
        size_y      <= b.sy;
        size_z      <= b.sz;
        center_only <= b.c_only;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        // Item taken at this edge: queue its expected visibility
        pending_visibility.push_back(box_visible(b));
        n_sent++;
        if (b.c_only)
            n_center_only++;
    endtask

    task automatic send_with_gap(box_t b);
        int g;
        send_box(b);
        g = gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    // Wait out all expected results plus pipeline latency before touching config
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_visibility.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    task automatic write_reg(logic [bfv_pkg::CFG_IDX_W-1:0] idx, logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx < bfv_pkg::CFG_REGS)
            matrix_shadow[idx] = value;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic signed [31:0] rand_coord();
        int r;
        r = $urandom_range(0, 9);
        // Keep most values near the unit cube so visibility flips often
        if (r < 6)
            return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
        if (r < 8)
            return $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
        return $signed($urandom());
    endfunction

    function automatic box_t rand_box();
        box_t b;
        b.cx = rand_coord();
        b.cy = rand_coord();
        b.cz = rand_coord();
        b.sx = rand_coord();
        b.sy = rand_coord();
        b.sz = rand_coord();
        b.c_only = ($urandom_range(0, 3) == 0);
        return b;
    endfunction

    function automatic logic [31:0] rand_entry();
        int r;
        r = $urandom_range(0, 7);
        if (r < 5)
            return $signed($urandom_range(0, 32'h0003_0000)) - 32'sh0001_8000;
        if (r < 7)
            return 32'h0;
        return $urandom();
    endfunction

    task automatic load_random_matrix();
        for (int i = 0; i < bfv_pkg::CFG_REGS; i++)
            write_reg(i[bfv_pkg::CFG_IDX_W-1:0], {rand_entry(), rand_entry()});
        // Keep w positive and dominant on some settings so boxes fall inside
        if ($urandom_range(0, 1))
            write_reg(REG_R3_C23, {32'h0001_0000 + ($urandom() & 32'h0000_ffff),
                                   rand_entry()});
    endtask

    task automatic load_identity();
        write_reg(REG_R0_C01, ONE_ENTRY);
        write_reg(REG_R0_C23, 64'h0);
        write_reg(REG_R1_C01, ONE_HIGH);
        write_reg(REG_R1_C23, 64'h0);
        write_reg(REG_R2_C01, 64'h0);
        write_reg(REG_R2_C23, ONE_ENTRY);
        write_reg(REG_R3_C01, 64'h0);
        write_reg(REG_R3_C23, ONE_HIGH);
    endtask

    function automatic box_t mk_box(int cx, int cy, int cz, int sx, int sy, int sz,
                                    bit c_only);
        box_t b;
        b.cx = cx;
        b.cy = cy;
        b.cz = cz;
        b.sx = sx;
        b.sy = sy;
        b.sz = sz;
        b.c_only = c_only;
        return b;
    endfunction

    // Reset-value matrix: boxes near the clip volume, corners straddling,
    // negative sizes, field extremes and the center-only mode.
    task automatic test_directed_reset_matrix();
        send_with_gap(mk_box(32'sh0000_8000, 0, 32'sh0000_8000, 0, 0, 0, 1'b1));
        send_with_gap(mk_box(32'sh0000_8000, 0, 32'sh0000_8000, 0, 0, 0, 1'b0));
        send_with_gap(mk_box(32'sh0003_0000, 0, 32'sh0000_8000, 32'sh0001_0000, 0, 0, 1'b1));
        send_with_gap(mk_box(32'sh0003_0000, 0, 32'sh0000_8000, 32'sh0008_0000, 0, 0, 1'b0));
        send_with_gap(mk_box(0, 0, 32'sh0000_8000, -32'sh0004_0000, -1, -1, 1'b0));
        send_with_gap(mk_box(32'sh0001_0000, 0, 32'sh0000_8000, 0, 0, 0, 1'b1));
        send_with_gap(mk_box(0, 0, 0, 0, 0, 0, 1'b1));
        send_with_gap(mk_box(0, 0, 32'sh0001_0000, 0, 0, 0, 1'b1));
        send_with_gap(mk_box(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                             32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 1'b0));
        send_with_gap(mk_box(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                             32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b0));
        send_with_gap(mk_box(-1, -1, -1, -1, -1, -1, 1'b1));
        send_with_gap(mk_box(32'sh8000_0000, 32'sh7fff_ffff, 32'sh0000_8000,
                             32'sh7fff_ffff, 32'sh8000_0000, 1, 1'b0));
        drain();
    endtask

    // Zero w for every point, then perspective-like, all-ones and full-scale matrices.
    task automatic test_directed_special_matrices();
        write_reg(REG_R3_C23, 64'h0);
        write_reg(REG_OUT_OF_RANGE, 64'hffff_ffff_ffff_ffff);
        send_with_gap(mk_box(32'sh0000_8000, 0, 32'sh0000_8000, 0, 0, 0, 1'b1));
        send_with_gap(mk_box(32'sh0000_8000, 0, 32'sh0000_8000, 32'sh0001_0000,
                             32'sh0001_0000, 32'sh0001_0000, 1'b0));
        drain();
        // w = z, z' = z/2: negative w flips the comparisons
        write_reg(REG_R2_C23, 64'h0001_0000_0000_8000);
        write_reg(REG_R3_C23, 64'h0);
        send_with_gap(mk_box(0, 0, 32'sh0002_0000, 0, 0, 0, 1'b1));
        send_with_gap(mk_box(0, 0, -32'sh0002_0000, 0, 0, 0, 1'b1));
        send_with_gap(mk_box(0, 0, 0, 32'sh0002_0000, 32'sh0002_0000, 32'sh0002_0000, 1'b0));
        drain();
        for (int i = 0; i < bfv_pkg::CFG_REGS; i++)
            write_reg(i[bfv_pkg::CFG_IDX_W-1:0], 64'hffff_ffff_ffff_ffff);
        send_with_gap(mk_box(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 0, 0, 0, 1'b1));
        send_with_gap(mk_box(32'sh8000_0000, 32'sh7fff_ffff, 0, -1, 32'sh7fff_ffff, 0, 1'b0));
        drain();
        for (int i = 0; i < bfv_pkg::CFG_REGS; i++)
            write_reg(i[bfv_pkg::CFG_IDX_W-1:0], 64'h8000_0000_7fff_ffff);
        send_with_gap(mk_box(32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff,
                             32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 1'b0));
        send_with_gap(mk_box(-32'sh0001_0000, 32'sh0001_0000, 0, 0, 0, 0, 1'b1));
        drain();
        load_identity();
    endtask

    // Random boxes against identity and random matrices, bank rewritten between phases.
    task automatic test_random_boxes(int n_phases, int per_phase);
        for (int p = 0; p < n_phases; p++)
        begin
            if (p % 4 == 0)
                load_identity();
            else
                load_random_matrix();
            for (int i = 0; i < per_phase; i++)
                send_with_gap(rand_box());
            drain();
        end
    endtask

    // Back-to-back items while the receiver holds off: the pipeline must fill and stall.
    task automatic test_backpressure();
        random_stall_en = 1'b0;
        hold_cycles = 40;
        for (int i = 0; i < 30; i++)
            send_box(rand_box());
        in_valid <= 1'b0;
        while (hold_cycles != 0)
            @(posedge clk);
        random_stall_en = 1'b1;
        drain();
    endtask

    // Receiver stall: a long hold-off on request, random gaps otherwise,
    // with quiet stretches that leave the output open.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else if (hold_cycles > 0)
        begin
            out_stall   <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else if (random_stall_en && ($urandom_range(0, 255) > 8))
        begin
            out_stall <= ($urandom_range(0, 99) < 30);
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // Compare each result taken with the oldest visibility still owed
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_visibility.size() == 0)
            begin
                $error("unexpected result: inside_res=%0b with nothing pending", inside_res);
                n_errors++;
            end
            else
            begin
                logic exp_vis;
                exp_vis = pending_visibility.pop_front();
                n_checked++;
                if (exp_vis)
                    n_visible++;
                if (inside_res !== exp_vis)
                begin
                    $error("inside_res mismatch: expected %0b, actual %0b", exp_vis, inside_res);
                    n_errors++;
                end
            end
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        center_x        = '0;
        center_y        = '0;
        center_z        = '0;
        size_x          = '0;
        size_y          = '0;
        size_z          = '0;
        center_only     = 1'b0;
        cfg_valid       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        hold_cycles     = 0;
        random_stall_en = 1'b1;
        n_errors        = 0;
        n_sent          = 0;
        n_checked       = 0;
        n_visible       = 0;
        n_center_only   = 0;
        for (int i = 0; i < bfv_pkg::CFG_REGS; i++)
            matrix_shadow[i] = bfv_pkg::CFG_RESET[i];

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_reset_matrix();
        test_directed_special_matrices();
        test_backpressure();
        test_random_boxes(20, 50);

        drain();
        $display("Checked %0d of %0d boxes (%0d center-only, %0d visible)",
                 n_checked, n_sent, n_center_only, n_visible);
        $display("Identity, zero-w, perspective, full-scale and random matrices were used");
        if (n_errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Timeout guard
    initial
    begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
